[rtl/cgb_pkg.sv]
// shared constants, types and helpers of the grid binner
package cgb_pkg;

    localparam int NUM_AXES          = 3;
    localparam int TOTAL_CELLS       = 65536;
    localparam int CNT_AW            = $clog2(TOTAL_CELLS);
    localparam int MAX_SPLIT_ENTRIES = 17;
    localparam int SPLIT_AW          = $clog2(MAX_SPLIT_ENTRIES);
    localparam int CNT_W             = 24;
    localparam int DIV_W             = 48;
    localparam int DIV_CW            = $clog2(DIV_W);
    localparam int IDX_W             = 29;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_BIN  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_WARN  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic [2:0] CFG_BIN_WIDTH = 3'd0;
    localparam logic [2:0] CFG_BINS0     = 3'd1;
    localparam logic [2:0] CFG_BINS1     = 3'd2;
    localparam logic [2:0] CFG_BINS2     = 3'd3;
    localparam logic [2:0] CFG_SPLITS    = 3'd4;
    localparam logic [2:0] CFG_COUNT_EN  = 3'd5;

    localparam logic [49:0] EPS_Q     = 50'd66;
    localparam logic [41:0] TOL_Q     = 42'd655;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [CNT_AW-1:0] addr;
        logic [CNT_W-1:0]  wdata;
    } cnt_req_t;

    function automatic logic [8:0] eff_bins(input logic [8:0] r);
        logic [8:0] v;
        v = r;
        if (r == 9'd0) v = 9'd1;
        else if (r > 9'd256) v = 9'd256;
        return v;
    endfunction

endpackage

[rtl/coordinate_grid_binner.sv]
// top level: request sequencer, split table and configuration of the grid binner
//
// Each word is one request. A load writes one row-split entry and a read
// returns one cell count. A load goes from idle straight to the done state,
// and a read passes through the count wait state on its way there; from done
// the result is loaded into the output register once it is free. A bin
// request first walks the split table one entry per cycle (at most 16
// entries), then handles the three axes in turn. Each axis passes through a
// start state, a serial divide of the coordinate by the cell width (48
// quotient bits), a clamping state and an index arithmetic state. A bin ends
// with the flat index check, the optional read-modify-write of the count
// memory and the output load. After reset the count memory is cleared one
// cell per cycle over all 65536 cells; no word is taken during the sweep,
// while configuration writes are taken at any time.
module coordinate_grid_binner (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [4:0]         s_split_slot,
    input  logic [23:0]        s_split_value,
    input  logic [23:0]        s_vertex_index,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic signed [31:0] s_coord_z,
    input  logic [15:0]        s_count_address,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [7:0]         m_cell_x,
    output logic [7:0]         m_cell_y,
    output logic [7:0]         m_cell_z,
    output logic [4:0]         m_segment,
    output logic [15:0]        m_flat_cell,
    output logic [23:0]        m_cell_count
);
    import cgb_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SEG      = 4'd1;
    localparam logic [3:0] ST_AX_START = 4'd2;
    localparam logic [3:0] ST_AX_DIV   = 4'd3;
    localparam logic [3:0] ST_AX_FIN   = 4'd4;
    localparam logic [3:0] ST_ACC      = 4'd5;
    localparam logic [3:0] ST_FLAT     = 4'd6;
    localparam logic [3:0] ST_CNT_RD   = 4'd7;
    localparam logic [3:0] ST_CNT_WAIT = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

    // configuration
    logic [30:0] bin_width_reg;
    logic [8:0]  bins_reg [NUM_AXES];
    logic [4:0]  split_entries_reg;
    logic        count_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_width_reg     <= 31'd65536;
            bins_reg[0]       <= 9'd1;
            bins_reg[1]       <= 9'd1;
            bins_reg[2]       <= 9'd1;
            split_entries_reg <= 5'd1;
            count_en_reg      <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BIN_WIDTH: bin_width_reg     <= cfg_wdata;
                CFG_BINS0:     bins_reg[0]       <= cfg_wdata[8:0];
                CFG_BINS1:     bins_reg[1]       <= cfg_wdata[8:0];
                CFG_BINS2:     bins_reg[2]       <= cfg_wdata[8:0];
                CFG_SPLITS:    split_entries_reg <= cfg_wdata[4:0];
                CFG_COUNT_EN:  count_en_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [30:0] w_eff;
    logic [4:0]  ne_eff;

    assign w_eff = (bin_width_reg == 31'd0) ? 31'd1 : bin_width_reg;

    always_comb begin
        ne_eff = split_entries_reg;
        if (split_entries_reg == 5'd0) ne_eff = 5'd1;
        else if (split_entries_reg > 5'(MAX_SPLIT_ENTRIES)) ne_eff = 5'(MAX_SPLIT_ENTRIES);
    end

    // sequencer registers
    logic [3:0]        state_reg;
    logic [1:0]        req_reg;
    logic [23:0]       vert_reg;
    logic [31:0]       coord_reg [NUM_AXES];
    logic [1:0]        axis_reg;
    logic [4:0]        i_reg;
    logic [4:0]        seg_reg;
    logic [IDX_W-1:0]  acc_reg;
    logic [39:0]       nbw_reg;
    logic              warn_reg;
    logic [1:0]        res_status_reg;
    logic [7:0]        res_cell_reg [NUM_AXES];
    logic [15:0]       res_flat_reg;
    logic [CNT_W-1:0]  res_count_reg;

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    // split table
    logic [23:0]         sp_mem [MAX_SPLIT_ENTRIES];
    logic [23:0]         sp_rdata_reg;
    logic [SPLIT_AW-1:0] sp_raddr;
    logic                sp_we;

    assign sp_raddr = (state_reg == ST_SEG) ? SPLIT_AW'(i_reg + 5'd1) : SPLIT_AW'(1);
    assign sp_we    = s_fire && (s_req_type == REQ_LOAD) &&
                      (s_split_slot < 5'(MAX_SPLIT_ENTRIES));

    always_ff @(posedge aclk) begin
        if (sp_we) sp_mem[s_split_slot[SPLIT_AW-1:0]] <= s_split_value;
        sp_rdata_reg <= sp_mem[sp_raddr];
    end

    // count memory
    cnt_req_t         cnt_req;
    logic [CNT_W-1:0] cnt_rdata;
    logic             clearing;

    always_comb begin
        cnt_req.rd_en = (s_fire && (s_req_type == REQ_READ)) || (state_reg == ST_CNT_RD);
        cnt_req.wr_en = (state_reg == ST_CNT_WAIT) && (req_reg == REQ_BIN);
        cnt_req.addr  = (state_reg == ST_IDLE) ? s_count_address : acc_reg[CNT_AW-1:0];
        cnt_req.wdata = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;
    end

    cgb_counts u_counts (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (cnt_req),
        .rd_data  (cnt_rdata),
        .clearing (clearing)
    );

    // per-axis divide
    logic [31:0]      coord_cur;
    logic [8:0]       nb_sel;
    logic [31:0]      coord_mag;
    logic             div_start;
    logic             div_busy;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic             div_rem_nz;

    assign coord_cur = coord_reg[axis_reg];
    assign nb_sel    = eff_bins(bins_reg[axis_reg]);
    assign coord_mag = coord_cur[31] ? (~coord_cur + 32'd1) : coord_cur;
    assign div_start = state_reg == ST_AX_START;

    cgb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({coord_mag, 16'd0}),
        .divisor  (w_eff),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem_nz   (div_rem_nz)
    );

    // clamp and top-edge test
    logic [49:0]        q_mag;
    logic [49:0]        s_val;
    logic [33:0]        raw;
    logic               s_neg;
    logic               over;
    logic               at_top;
    logic signed [41:0] diff;
    logic [41:0]        absd;
    logic               near;
    logic [7:0]         c_val;
    logic               warn_ax;
    logic [IDX_W+8:0]   mac;
    logic [IDX_W-1:0]   acc_base;

    always_comb begin
        q_mag   = {2'b00, div_quot} + {49'd0, div_rem_nz};
        s_val   = (coord_cur[31] ? (~q_mag + 50'd1) : q_mag) + EPS_Q;
        s_neg   = s_val[49];
        raw     = s_val[49:16];
        over    = raw >= {25'd0, nb_sel};
        at_top  = raw == {25'd0, nb_sel};
        diff    = $signed({{10{coord_cur[31]}}, coord_cur}) - $signed({2'b00, nbw_reg});
        absd    = diff[41] ? (~diff + 42'd1) : diff;
        near    = absd < TOL_Q;
        warn_ax = s_neg || (over && !(at_top && near));
        if (s_neg) c_val = 8'd0;
        else if (over) c_val = 8'(nb_sel - 9'd1);
        else c_val = raw[7:0];
        acc_base = (axis_reg == 2'd0) ? IDX_W'(seg_reg) : acc_reg;
        mac      = acc_base * nb_sel + {{(IDX_W+1){1'b0}}, res_cell_reg[axis_reg]};
    end

    logic out_load;
    assign out_load = (state_reg == ST_DONE) && (!m_valid || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        unique case (s_req_type)
                            REQ_BIN: state_reg <= (ne_eff > 5'd1) ? ST_SEG : ST_AX_START;
                            REQ_READ: state_reg <= ST_CNT_WAIT;
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_SEG: begin
                    if (sp_rdata_reg > vert_reg || (i_reg + 5'd1) >= ne_eff)
                        state_reg <= ST_AX_START;
                end
                ST_AX_START: state_reg <= ST_AX_DIV;
                ST_AX_DIV:   if (div_done) state_reg <= ST_AX_FIN;
                ST_AX_FIN:   state_reg <= ST_ACC;
                ST_ACC: begin
                    state_reg <= (axis_reg == 2'(NUM_AXES - 1)) ? ST_FLAT : ST_AX_START;
                end
                ST_FLAT: begin
                    if (acc_reg >= IDX_W'(TOTAL_CELLS) || !count_en_reg) state_reg <= ST_DONE;
                    else state_reg <= ST_CNT_RD;
                end
                ST_CNT_RD:   state_reg <= ST_CNT_WAIT;
                ST_CNT_WAIT: state_reg <= ST_DONE;
                ST_DONE:     if (out_load) state_reg <= ST_IDLE;
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg <= '0;
        end else if (s_fire) begin
            seg_reg <= '0;
        end else if (state_reg == ST_SEG && !(sp_rdata_reg > vert_reg)) begin
            seg_reg <= seg_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg        <= s_req_type;
            vert_reg       <= s_vertex_index;
            coord_reg[0]   <= s_coord_x;
            coord_reg[1]   <= s_coord_y;
            coord_reg[2]   <= s_coord_z;
            axis_reg       <= '0;
            i_reg          <= 5'd1;
            warn_reg       <= 1'b0;
            res_cell_reg[0] <= '0;
            res_cell_reg[1] <= '0;
            res_cell_reg[2] <= '0;
            res_flat_reg   <= (s_req_type == REQ_READ) ? s_count_address : 16'd0;
            res_count_reg  <= '0;
            res_status_reg <= (s_req_type == REQ_LOAD && !sp_we) ? STAT_RANGE : STAT_OK;
        end
        unique case (state_reg)
            ST_SEG: i_reg <= i_reg + 5'd1;
            ST_AX_START: nbw_reg <= nb_sel * w_eff;
            ST_AX_FIN: begin
                res_cell_reg[axis_reg] <= c_val;
                warn_reg <= warn_reg | warn_ax;
            end
            ST_ACC: begin
                acc_reg  <= mac[IDX_W-1:0];
                axis_reg <= axis_reg + 2'd1;
            end
            ST_FLAT: begin
                if (acc_reg >= IDX_W'(TOTAL_CELLS)) begin
                    res_status_reg <= STAT_RANGE;
                end else begin
                    res_status_reg <= warn_reg ? STAT_WARN : STAT_OK;
                    res_flat_reg   <= acc_reg[15:0];
                end
            end
            ST_CNT_WAIT: if (req_reg == REQ_READ) res_count_reg <= cnt_rdata;
            default: ;
        endcase
    end

    // output register
    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [7:0]  m_cell_x_reg;
    logic [7:0]  m_cell_y_reg;
    logic [7:0]  m_cell_z_reg;
    logic [4:0]  m_segment_reg;
    logic [15:0] m_flat_reg;
    logic [23:0] m_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg  <= res_status_reg;
            m_cell_x_reg  <= res_cell_reg[0];
            m_cell_y_reg  <= res_cell_reg[1];
            m_cell_z_reg  <= res_cell_reg[2];
            m_segment_reg <= (req_reg == REQ_BIN) ? seg_reg : 5'd0;
            m_flat_reg    <= res_flat_reg;
            m_count_reg   <= res_count_reg;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE) && !clearing;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_cell_x     = m_cell_x_reg;
    assign m_cell_y     = m_cell_y_reg;
    assign m_cell_z     = m_cell_z_reg;
    assign m_segment    = m_segment_reg;
    assign m_flat_cell  = m_flat_reg;
    assign m_cell_count = m_count_reg;

`ifndef SYNTHESIS
    a_div_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> state_reg == ST_AX_DIV)
        else $error("divider busy outside the divide state");
    a_no_write_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_req.wr_en |-> !clearing)
        else $error("count write during clearing sweep");
    a_count_addr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CNT_RD |-> acc_reg < IDX_W'(TOTAL_CELLS))
        else $error("count access beyond memory");
    a_segment_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_reg < 5'(MAX_SPLIT_ENTRIES))
        else $error("segment beyond split table");
`endif

endmodule

[rtl/cgb_div.sv]
// serial restoring divider, one quotient bit per cycle
module cgb_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cgb_pkg::DIV_W-1:0] dividend,
    input  logic [30:0]               divisor,
    output logic                      busy,
    output logic                      done,
    output logic [cgb_pkg::DIV_W-1:0] quot,
    output logic                      rem_nz
);
    import cgb_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [30:0]       rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [31:0]       shifted;
    logic [31:0]       diffv;
    logic              ge;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diffv   = shifted - {1'b0, divisor};
    assign ge      = shifted >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? diffv[30:0] : shifted[30:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign quot   = quo_reg;
    assign rem_nz = rem_reg != 31'd0;

endmodule

[rtl/cgb_counts.sv]
// per-cell count memory with a clearing sweep after reset
module cgb_counts (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cgb_pkg::cnt_req_t         req,
    output logic [cgb_pkg::CNT_W-1:0] rd_data,
    output logic                      clearing
);
    import cgb_pkg::*;

    logic [CNT_W-1:0]  mem [TOTAL_CELLS];
    logic [CNT_W-1:0]  rd_data_reg;
    logic              clr_busy_reg;
    logic [CNT_AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {CNT_AW{1'b1}}) clr_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) rd_data_reg <= mem[req.addr];
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_busy_reg;

endmodule

[test/tb_coordinate_grid_binner.sv]
// self-checking testbench of the coordinate grid binner
module tb_coordinate_grid_binner;
    import cgb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [4:0]         split_slot;
        logic [23:0]        split_value;
        logic [23:0]        vertex_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [15:0]        count_address;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic [7:0]  cell_z;
        logic [4:0]  segment;
        logic [15:0] flat_cell;
        logic [23:0] cell_count;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [30:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_req_type = '0;
    logic [4:0] s_split_slot = '0;
    logic [23:0] s_split_value = '0;
    logic [23:0] s_vertex_index = '0;
    logic signed [31:0] s_coord_x = '0;
    logic signed [31:0] s_coord_y = '0;
    logic signed [31:0] s_coord_z = '0;
    logic [15:0] s_count_address = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_status;
    logic [7:0] m_cell_x, m_cell_y, m_cell_z;
    logic [4:0] m_segment;
    logic [15:0] m_flat_cell;
    logic [23:0] m_cell_count;

    coordinate_grid_binner dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic [23:0] split_copy [MAX_SPLIT_ENTRIES];
    logic [23:0] count_copy [TOTAL_CELLS];
    logic [30:0] width_reg;
    logic [8:0]  bins_reg [3];
    logic [4:0]  splits_reg;
    logic        count_en_reg;

    request_t pending_words [$];
    answer_t  expected_answers [$];
    int send_idle_pct = 0, recv_idle_pct = 0;
    int hold_off = 0;
    int errors = 0, bins_done = 0, reads_done = 0, loads_done = 0, answers_seen = 0;
    int quiet_cycles = 0;
    int written_slots = 0; // slots 0..written_slots-1 hold known values

    function automatic answer_t predict_answer(request_t r);
        answer_t a;
        longint w, coord, nb, s, q, diff, raw, c;
        longint mul, flat, seg, ne;
        logic warn;
        a = '0;
        case (r.req_type)
            REQ_LOAD: begin
                if (r.split_slot < MAX_SPLIT_ENTRIES) split_copy[r.split_slot] = r.split_value;
                else a.status = STAT_RANGE;
            end
            REQ_BIN: begin
                w = (width_reg == 0) ? 1 : longint'(width_reg);
                mul = 1; flat = 0; seg = 0; warn = 1'b0;
                for (int ax = 2; ax >= 0; ax--) begin
                    coord = (ax == 0) ? r.coord_x : (ax == 1) ? r.coord_y : r.coord_z;
                    nb = (bins_reg[ax] == 0) ? 1 : (bins_reg[ax] > 256) ? 256 : bins_reg[ax];
                    q = (coord * 65536) / w;
                    if (((coord * 65536) % w) != 0 && coord < 0) q = q - 1;
                    s = q + 66;
                    if (s < 0) begin
                        c = 0; warn = 1'b1;
                    end else begin
                        raw = s >>> 16;
                        c = raw;
                        if (raw >= nb) begin
                            diff = coord - nb * w;
                            if (diff < 0) diff = -diff;
                            if (!(raw == nb && diff < 655)) warn = 1'b1;
                            c = nb - 1;
                        end
                    end
                    if (ax == 0) a.cell_x = c[7:0];
                    else if (ax == 1) a.cell_y = c[7:0];
                    else a.cell_z = c[7:0];
                    flat += c * mul;
                    mul *= nb;
                end
                ne = (splits_reg == 0) ? 1 : (splits_reg > MAX_SPLIT_ENTRIES) ?
                     MAX_SPLIT_ENTRIES : splits_reg;
                for (int i = 1; i < ne; i++) begin
                    if (split_copy[i] > r.vertex_index) break;
                    seg++;
                end
                flat += seg * mul;
                a.segment = seg[4:0];
                if (flat >= TOTAL_CELLS) a.status = STAT_RANGE;
                else begin
                    a.status = warn ? STAT_WARN : STAT_OK;
                    a.flat_cell = flat[15:0];
                    if (count_en_reg && count_copy[flat] != COUNT_MAX)
                        count_copy[flat] = count_copy[flat] + 24'd1;
                end
            end
            REQ_READ: begin
                a.flat_cell = r.count_address;
                a.cell_count = count_copy[r.count_address];
            end
            default: ;
        endcase
        return a;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_answers.push_back(predict_answer({s_req_type, s_split_slot,
                    s_split_value, s_vertex_index, s_coord_x, s_coord_y, s_coord_z,
                    s_count_address}));
                case (s_req_type)
                    REQ_LOAD: loads_done++;
                    REQ_BIN:  bins_done++;
                    default:  reads_done++;
                endcase
            end
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                request_t r;
                r = pending_words.pop_front();
                s_valid <= 1'b1;
                {s_req_type, s_split_slot, s_split_value, s_vertex_index, s_coord_x,
                 s_coord_y, s_coord_z, s_count_address} <= r;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            answer_t e;
            answers_seen++;
            if (expected_answers.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = expected_answers.pop_front();
                if (m_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_status); errors++;
                end
                if (m_cell_x !== e.cell_x) begin
                    $error("cell_x exp %0d got %0d", e.cell_x, m_cell_x); errors++;
                end
                if (m_cell_y !== e.cell_y) begin
                    $error("cell_y exp %0d got %0d", e.cell_y, m_cell_y); errors++;
                end
                if (m_cell_z !== e.cell_z) begin
                    $error("cell_z exp %0d got %0d", e.cell_z, m_cell_z); errors++;
                end
                if (m_segment !== e.segment) begin
                    $error("segment exp %0d got %0d", e.segment, m_segment); errors++;
                end
                if (m_flat_cell !== e.flat_cell) begin
                    $error("flat_cell exp %0d got %0d", e.flat_cell, m_flat_cell); errors++;
                end
                if (m_cell_count !== e.cell_count) begin
                    $error("cell_count exp %0d got %0d", e.cell_count, m_cell_count);
                    errors++;
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: fails the test when no word moves on either side, with room for the clearing pass after reset
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 200000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_BIN_WIDTH: width_reg = val;
            CFG_BINS0:     bins_reg[0] = val[8:0];
            CFG_BINS1:     bins_reg[1] = val[8:0];
            CFG_BINS2:     bins_reg[2] = val[8:0];
            CFG_SPLITS:    splits_reg = val[4:0];
            default:       count_en_reg = val[0];
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_all();
        wait (pending_words.size() == 0 && !s_valid && expected_answers.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    function automatic request_t load_word(int slot, logic [23:0] v);
        request_t r;
        r = '0;
        r.req_type = REQ_LOAD; r.split_slot = slot[4:0]; r.split_value = v;
        r.vertex_index = 24'($urandom); r.coord_x = $urandom;
        return r;
    endfunction

    function automatic request_t read_word(logic [15:0] addr);
        request_t r;
        r = '0;
        r.req_type = REQ_READ; r.count_address = addr; r.coord_y = $urandom;
        return r;
    endfunction

    // coordinate mostly near the grid, sometimes anywhere
    function automatic logic [31:0] pick_coord(int nb);
        longint w, v;
        w = (width_reg == 0) ? 1 : width_reg;
        case ($urandom_range(9))
            0: return $urandom;
            1: v = nb * w + $signed($urandom_range(1400)) - 700;
            2: v = -longint'($urandom_range(1000));
            default: v = longint'($urandom_range(nb * 4)) * w / 4 +
                         longint'($urandom_range(3));
        endcase
        if (v > 64'sh7fffffff) v = 64'sh7fffffff;
        if (v < -64'sh80000000) v = -64'sh80000000;
        return v[31:0];
    endfunction

    function automatic request_t bin_word();
        request_t r;
        r = '0;
        r.req_type = REQ_BIN;
        r.vertex_index = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(4000));
        r.coord_x = pick_coord(bins_reg[0] == 0 ? 1 : bins_reg[0]);
        r.coord_y = pick_coord(bins_reg[1] == 0 ? 1 : bins_reg[1]);
        r.coord_z = pick_coord(bins_reg[2] == 0 ? 1 : bins_reg[2]);
        r.split_slot = 5'($urandom); r.split_value = 24'($urandom);
        r.count_address = 16'($urandom);
        return r;
    endfunction

    function automatic request_t random_word();
        int k;
        request_t r;
        k = $urandom_range(99);
        if (k < 70) return bin_word();
        if (k < 85) return read_word(16'($urandom));
        if (k < 95) return load_word($urandom_range(written_slots), 24'($urandom_range(4000)));
        r = load_word(0, 0);
        if (k < 98) r.split_slot = 5'($urandom_range(31, MAX_SPLIT_ENTRIES));
        else r.req_type = 2'd3;
        return r;
    endfunction

    // split values ascending so segments spread over the range
    task automatic load_splits(int n);
        for (int i = 0; i <= n; i++)
            pending_words.push_back(load_word(i, 24'(i * 250)));
        written_slots = n + 1;
    endtask

    initial begin
        request_t r;
        for (int i = 0; i < TOTAL_CELLS; i++) count_copy[i] = '0;
        for (int i = 0; i < MAX_SPLIT_ENTRIES; i++) split_copy[i] = '0;
        width_reg = 31'd65536; bins_reg = '{9'd1, 9'd1, 9'd1};
        splits_reg = 5'd1; count_en_reg = 1'b1;
        send_idle_pct = 22; recv_idle_pct = 56;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: defaults, extremes, all request kinds
        write_reg(CFG_SPLITS, 31'd5);
        write_reg(CFG_BINS0, 31'd4);
        write_reg(CFG_BINS1, 31'd256);
        write_reg(CFG_BINS2, 31'd0);
        write_reg(CFG_BIN_WIDTH, 31'd65536);
        write_reg(CFG_COUNT_EN, 31'd1);
        load_splits(4);
        r = bin_word(); r.coord_x = 0; r.coord_y = 0; r.coord_z = 0; r.vertex_index = 0;
        pending_words.push_back(r);
        r.coord_x = 32'sh7fffffff; r.coord_y = 32'sh80000000; r.vertex_index = 24'hffffff;
        pending_words.push_back(r);
        r.coord_x = 4 * 65536 + 100; r.coord_y = 256 * 65536 - 300; r.vertex_index = 600;
        pending_words.push_back(r);
        r.coord_x = 4 * 65536 + 700; r.coord_z = -1;
        pending_words.push_back(r);
        r.coord_x = -66; r.coord_y = 65536 - 66; r.coord_z = 65536;
        pending_words.push_back(r);
        r = load_word(0, 0); r.split_slot = 5'd31; pending_words.push_back(r);
        r = load_word(0, 0); r.split_slot = 5'd17; pending_words.push_back(r);
        r = load_word(0, 0); r.req_type = 2'd3; pending_words.push_back(r);
        pending_words.push_back(read_word(0));
        pending_words.push_back(read_word(16'hffff));
        pending_words.push_back(read_word(16'h5555));
        drain_all();

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 56; recv_idle_pct = 22;
            end else if (ph == 6) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            case (ph)
                0: begin
                    write_reg(CFG_BIN_WIDTH, 31'd0);
                    write_reg(CFG_BINS0, 31'd300); write_reg(CFG_BINS1, 31'd1);
                    write_reg(CFG_BINS2, 31'd1); write_reg(CFG_SPLITS, 31'd0);
                end
                1: begin
                    write_reg(CFG_BIN_WIDTH, 31'h7fffffff);
                    write_reg(CFG_BINS0, 31'd256); write_reg(CFG_BINS1, 31'd256);
                    write_reg(CFG_BINS2, 31'd511); write_reg(CFG_COUNT_EN, 31'd0);
                end
                2: begin
                    write_reg(CFG_BIN_WIDTH, 31'd32768);
                    write_reg(CFG_BINS0, 31'd8); write_reg(CFG_BINS1, 31'd8);
                    write_reg(CFG_BINS2, 31'd8); write_reg(CFG_COUNT_EN, 31'd1);
                    write_reg(CFG_SPLITS, 31'd31);
                    load_splits(16);
                end
                default: begin
                    write_reg(CFG_BIN_WIDTH, 31'($urandom_range(1 << 20, 1)));
                    write_reg(CFG_BINS0, 31'($urandom_range(16, 1)));
                    write_reg(CFG_BINS1, 31'($urandom_range(16, 1)));
                    write_reg(CFG_BINS2, 31'($urandom_range(16, 1)));
                    write_reg(CFG_SPLITS, 31'($urandom_range(MAX_SPLIT_ENTRIES, 1)));
                    write_reg(CFG_COUNT_EN, 31'($urandom_range(1)));
                end
            endcase
            // split entries read by bins must be known
            if (written_slots < splits_reg && written_slots < MAX_SPLIT_ENTRIES)
                load_splits(MAX_SPLIT_ENTRIES - 1);
            if (ph == 4) hold_off = 3000;
            for (int n = 0; n < 190; n++) pending_words.push_back(random_word());
            drain_all();
        end

        $display("covered %0d bins, %0d reads, %0d loads; %0d result words checked",
                 bins_done, reads_done, loads_done, answers_seen);
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
